[src/mck_pkg.sv]
package mck_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int DUR_W     = 16;
    localparam int STEP_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DOT      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_GAP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_GAP = 8'd3;

    localparam logic [DUR_W-1:0] RST_DOT      = 16'd100;
    localparam logic [DUR_W-1:0] RST_DASH     = 16'd300;
    localparam logic [DUR_W-1:0] RST_ELEM_GAP = 16'd100;
    localparam logic [DUR_W-1:0] RST_CHAR_GAP = 16'd700;

    // code byte: [7:5] element count, [4:0] elements, first in highest used bit, 1 = dash
    localparam logic [7:0] LETTER_CODES [26] = '{
        8'h41, 8'h88, 8'h8A, 8'h64, 8'h20, 8'h82, 8'h66, 8'h80, 8'h40, 8'h87,
        8'h65, 8'h84, 8'h43, 8'h42, 8'h67, 8'h86, 8'h8D, 8'h62, 8'h60, 8'h21,
        8'h61, 8'h81, 8'h63, 8'h89, 8'h8B, 8'h8C
    };

    localparam logic [7:0] DIGIT_CODES [10] = '{
        8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1, 8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE
    };

    // microprogram steps
    localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MARK  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_EGAP  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_CGAP  = 3'd4;

    typedef enum logic [1:0] {
        H_NONE,
        H_IN,
        H_OUT
    } t_hold;

    typedef enum logic [1:0] {
        B_SEQ,
        B_JMP,
        B_IF_LEN0,
        B_IF_LEN_GT1
    } t_branch;

    typedef enum logic [1:0] {
        D_ELEM,
        D_EGAP,
        D_CGAP
    } t_dur_sel;

    typedef struct packed {
        t_hold              hold;
        t_branch            branch;
        logic [STEP_W-1:0]  target;
        logic               led;
        logic               last;
        logic               shift;
        t_dur_sel           dur;
    } t_uword;

    typedef struct packed {
        logic     load;
        logic     shift;
        logic     led;
        logic     last;
        t_dur_sel dur;
    } t_ctrl;

    typedef struct packed {
        logic len_zero;
        logic len_gt1;
    } t_stat;

    typedef struct packed {
        logic [DUR_W-1:0] dot;
        logic [DUR_W-1:0] dash;
        logic [DUR_W-1:0] elem_gap;
        logic [DUR_W-1:0] char_gap;
    } t_cfg;

endpackage

[src/mck_cfg_regs.sv]
module mck_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mck_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mck_pkg::DUR_W-1:0]     i_cfg_data,
    output mck_pkg::t_cfg                 o_cfg
);
    import mck_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot      <= RST_DOT;
            r_cfg.dash     <= RST_DASH;
            r_cfg.elem_gap <= RST_ELEM_GAP;
            r_cfg.char_gap <= RST_CHAR_GAP;
        end else if (i_cfg_valid) begin
            // unknown indexes are dropped
            unique case (i_cfg_index)
                CFG_DOT:      r_cfg.dot      <= i_cfg_data;
                CFG_DASH:     r_cfg.dash     <= i_cfg_data;
                CFG_ELEM_GAP: r_cfg.elem_gap <= i_cfg_data;
                CFG_CHAR_GAP: r_cfg.char_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[src/mck_decode.sv]
module mck_decode (
    input  logic [7:0] i_char,
    output logic [7:0] o_code
);
    import mck_pkg::*;

    logic [7:0] w_up;
    logic [7:0] w_let_off;
    logic [7:0] w_dig_off;

    assign w_up      = (i_char >= 8'h61 && i_char <= 8'h7A) ? i_char - 8'h20 : i_char;
    assign w_let_off = w_up - 8'h41;
    assign w_dig_off = w_up - 8'h30;

    always_comb begin
        if (w_up >= 8'h41 && w_up <= 8'h5A) begin
            o_code = LETTER_CODES[w_let_off[4:0]];
        end else if (w_up >= 8'h30 && w_up <= 8'h39) begin
            o_code = DIGIT_CODES[w_dig_off[3:0]];
        end else begin
            o_code = 8'h00;
        end
    end

endmodule

[src/mck_useq.sv]
module mck_useq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  mck_pkg::t_stat i_stat,
    output mck_pkg::t_ctrl o_ctrl
);
    import mck_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w_uw;
    logic              w_done;
    logic              w_take;

    function automatic t_uword urom(input logic [STEP_W-1:0] step);
        t_uword uw;
        uw = '{hold: H_NONE, branch: B_JMP, target: STEP_FETCH,
               led: 1'b0, last: 1'b0, shift: 1'b0, dur: D_ELEM};
        unique case (step)
            STEP_FETCH: begin
                uw.hold   = H_IN;
                uw.branch = B_SEQ;
            end
            STEP_CHECK: begin
                uw.branch = B_IF_LEN0;
                uw.target = STEP_FETCH;
            end
            STEP_MARK: begin
                uw.hold   = H_OUT;
                uw.branch = B_SEQ;
                uw.led    = 1'b1;
                uw.dur    = D_ELEM;
            end
            STEP_EGAP: begin
                uw.hold   = H_OUT;
                uw.branch = B_IF_LEN_GT1;
                uw.target = STEP_MARK;
                uw.shift  = 1'b1;
                uw.dur    = D_EGAP;
            end
            STEP_CGAP: begin
                uw.hold   = H_OUT;
                uw.branch = B_JMP;
                uw.target = STEP_FETCH;
                uw.last   = 1'b1;
                uw.dur    = D_CGAP;
            end
            default: ;
        endcase
        return uw;
    endfunction

    assign w_uw = urom(r_step);

    always_comb begin
        o_in_ready  = (w_uw.hold == H_IN);
        o_out_valid = (w_uw.hold == H_OUT);
        unique case (w_uw.hold)
            H_IN:    w_done = i_in_valid;
            H_OUT:   w_done = i_out_ready;
            default: w_done = 1'b1;
        endcase
    end

    always_comb begin
        unique case (w_uw.branch)
            B_JMP:        w_take = 1'b1;
            B_IF_LEN0:    w_take = i_stat.len_zero;
            B_IF_LEN_GT1: w_take = i_stat.len_gt1;
            default:      w_take = 1'b0;
        endcase
        if (!w_done) begin
            n_step = r_step;
        end else if (w_take) begin
            n_step = w_uw.target;
        end else begin
            n_step = r_step + 3'd1;
        end
    end

    always_comb begin
        o_ctrl.load  = o_in_ready & i_in_valid;
        o_ctrl.shift = w_uw.shift & w_done;
        o_ctrl.led   = w_uw.led;
        o_ctrl.last  = w_uw.last;
        o_ctrl.dur   = w_uw.dur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[src/mck_datapath.sv]
module mck_datapath (
    input  logic                      i_clk,
    input  logic [7:0]                i_code,
    input  mck_pkg::t_ctrl            i_ctrl,
    input  mck_pkg::t_cfg             i_cfg,
    output mck_pkg::t_stat            o_stat,
    output logic                      o_led_on,
    output logic [mck_pkg::DUR_W-1:0] o_duration_ms,
    output logic                      o_last
);
    import mck_pkg::*;

    logic [2:0] r_len;
    logic [4:0] r_bits;
    logic [2:0] w_amt;
    logic [4:0] w_bits;

    // left-align so the current element always sits in the top bit
    assign w_amt  = 3'd5 - i_code[7:5];
    assign w_bits = i_code[4:0] << w_amt;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_len  <= i_code[7:5];
            r_bits <= w_bits;
        end else if (i_ctrl.shift) begin
            r_len  <= r_len - 3'd1;
            r_bits <= {r_bits[3:0], 1'b0};
        end
    end

    assign o_stat.len_zero = (r_len == 3'd0);
    assign o_stat.len_gt1  = (r_len > 3'd1);

    assign o_led_on = i_ctrl.led;
    assign o_last   = i_ctrl.last;

    always_comb begin
        unique case (i_ctrl.dur)
            D_ELEM:  o_duration_ms = r_bits[4] ? i_cfg.dash : i_cfg.dot;
            D_EGAP:  o_duration_ms = i_cfg.elem_gap;
            default: o_duration_ms = i_cfg.char_gap;
        endcase
    end

endmodule

[src/morse_code_keyer_unit.sv]
// channel | valid       | ready       | payload
// --------+-------------+-------------+------------------------------------
// in      | i_in_valid  | o_in_ready  | i_char_code
// out     | o_out_valid | i_out_ready | o_led_on, o_duration_ms, o_last
// cfg     | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// One microcode step per cycle unless held: fetch, check, a lit and a dark
// segment per element, then the char gap; an unmapped character goes from
// check back to fetch. Fetch waits on i_in_valid, output steps on i_out_ready.
// Synchronous active-low reset returns to fetch and restores default timings.
// One character in flight at a time; cfg writes are always accepted.
module morse_code_keyer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_char_code,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_led_on,
    output logic [mck_pkg::DUR_W-1:0]     o_duration_ms,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mck_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mck_pkg::DUR_W-1:0]     i_cfg_data
);
    import mck_pkg::*;

    t_cfg       w_cfg;
    t_ctrl      w_ctrl;
    t_stat      w_stat;
    logic [7:0] w_code;

    mck_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mck_decode u_dec (
        .i_char (i_char_code),
        .o_code (w_code)
    );

    mck_useq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    mck_datapath u_dp (
        .i_clk         (i_clk),
        .i_code        (w_code),
        .i_ctrl        (w_ctrl),
        .i_cfg         (w_cfg),
        .o_stat        (w_stat),
        .o_led_on      (o_led_on),
        .o_duration_ms (o_duration_ms),
        .o_last        (o_last)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output requests open together");

    a_last_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> !o_led_on)
        else $error("final segment is lit");

    a_mark_then_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_led_on) |=> (o_out_valid && !o_led_on && !o_last))
        else $error("lit segment not followed by element gap");

    a_last_to_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("no fetch after final segment");

endmodule
